/* src/cws_pkg.sv */
// Shared constants, types and a helper function for the Walsh spreader.
`default_nettype none

package cws_pkg;

    // Default code length; the top level may override it within 2..8.
    localparam int CODE_LEN_DEF = 8;
    localparam int MAX_USERS    = 8;

    localparam int SYM_W   = 2;
    localparam int SUM_W   = 5;
    localparam int IDX_W   = 3;
    localparam int USERS_W = 4;
    localparam int SPC_W   = 4;

    localparam int S_DATA_W = MAX_USERS * SYM_W;
    localparam int M_DATA_W = 8;

    // Active user count and row spacing, settled when the register is written.
    typedef struct packed {
        logic [USERS_W-1:0] n_active;
        logic [SPC_W-1:0]   spacing;
    } cws_cfg_t;

    // Maps a 2-bit symbol code onto -1, 0 or +1; the unused code 10 reads as -1.
    function automatic logic signed [SYM_W-1:0] sym_val(input logic [SYM_W-1:0] raw);
        logic signed [SYM_W-1:0] v;
        case (raw)
            2'b00:   v = 2'sd0;
            2'b01:   v = 2'sd1;
            default: v = -2'sd1;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/cws_cfg.sv */
// Configuration register: clamps the user count and derives the row spacing.
`default_nettype none

module cws_cfg #(
    parameter int CODE_LEN = cws_pkg::CODE_LEN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cws_pkg::USERS_W-1:0]   cfg_wdata,
    output cws_pkg::cws_cfg_t                  cfg
);
    import cws_pkg::*;

    localparam logic [USERS_W-1:0] N_MAX = USERS_W'(CODE_LEN);

    logic [USERS_W-1:0] n_clamp;
    logic [SPC_W-1:0]   spacing_calc;
    cws_cfg_t           cfg_reg;
    cws_cfg_t           cfg_next;

    // Zero users counts as one; more users than code rows saturate.
    always_comb
    begin
        if (cfg_wdata == '0)
            n_clamp = USERS_W'(1);
        else if (cfg_wdata > N_MAX)
            n_clamp = N_MAX;
        else
            n_clamp = cfg_wdata;
    end

    always_comb
    begin
        case (n_clamp)
            4'd1:    spacing_calc = SPC_W'(CODE_LEN / 1);
            4'd2:    spacing_calc = SPC_W'(CODE_LEN / 2);
            4'd3:    spacing_calc = SPC_W'(CODE_LEN / 3);
            4'd4:    spacing_calc = SPC_W'(CODE_LEN / 4);
            4'd5:    spacing_calc = SPC_W'(CODE_LEN / 5);
            4'd6:    spacing_calc = SPC_W'(CODE_LEN / 6);
            4'd7:    spacing_calc = SPC_W'(CODE_LEN / 7);
            4'd8:    spacing_calc = SPC_W'(CODE_LEN / 8);
            default: spacing_calc = SPC_W'(1);
        endcase
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            cfg_next.n_active = n_clamp;
            cfg_next.spacing  = spacing_calc;
        end
    end

    // Reset value of eight users clamps to the code length, spacing one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.n_active <= N_MAX;
            cfg_reg.spacing  <= SPC_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/cws_chip.sv */
// Combinational chip sum: one Walsh chip summed over all active users.
`default_nettype none

module cws_chip #(
    parameter int CODE_LEN = cws_pkg::CODE_LEN_DEF
) (
    input  wire logic [cws_pkg::S_DATA_W-1:0]         syms,
    input  wire logic [$clog2(CODE_LEN)-1:0]          chip_idx,
    input  wire cws_pkg::cws_cfg_t                    cfg,
    output logic signed [cws_pkg::SUM_W-1:0]          chip_sum
);
    import cws_pkg::*;

    localparam int CNT_W  = $clog2(CODE_LEN);
    localparam int PROD_W = SPC_W + 3;

    logic signed [SUM_W-1:0] terms [MAX_USERS];

    // Each active user's row is u * spacing, always below the code length.
    always_comb
    begin
        logic [PROD_W-1:0]       prod;
        logic [CNT_W-1:0]        row;
        logic signed [SYM_W-1:0] s;
        for (int u = 0; u < MAX_USERS; u++)
        begin
            prod = PROD_W'(u) * PROD_W'(cfg.spacing);
            row  = prod[CNT_W-1:0];
            s    = sym_val(syms[u*SYM_W +: SYM_W]);
            if (USERS_W'(u) >= cfg.n_active)
                terms[u] = '0;
            else if (^(row & chip_idx))
                terms[u] = -SUM_W'(s);
            else
                terms[u] = SUM_W'(s);
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        acc = '0;
        for (int u = 0; u < MAX_USERS; u++)
            acc = acc + terms[u];
        chip_sum = acc;
    end

endmodule

`default_nettype wire

/* src/cdma_walsh_spreader_top.sv */
// Top level of the multi-user Walsh-Hadamard CDMA spreader.
//
//  Channel   Direction  Ports                                 Per request
//  s_*       in         s_tvalid s_tready s_tdata s_tlast     one symbol position
//  m_*       out        m_tvalid m_tready m_tdata m_tlast     one chip
//                       m_tuser
//  cfg_*     in         cfg_we cfg_wdata                      num_users write
//
// Each input request yields CODE_LEN chip requests, one per cycle unless the output
// stalls, so the block takes no new input request before the last chip of the current
// one is loaded; the single output channel and its chip counter set that limit.
// A chip is computed combinationally from the holding register and registered in the output register.
// The next input request is taken in the same cycle as the last chip of the
// previous one is loaded, so chips stream without gaps.
// Reset clears the holding and output valid flags, the chip counter and sets
// num_users to CODE_LEN. A stalled output holds its chip and stalls the counter.
`default_nettype none

module cdma_walsh_spreader_top #(
    parameter int CODE_LEN = cws_pkg::CODE_LEN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration: num_users in cfg_wdata.
    input  wire logic                          cfg_we,
    input  wire logic [cws_pkg::USERS_W-1:0]   cfg_wdata,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: sym_0 [1:0], sym_1 [3:2], ... sym_7 [15:14].
    input  wire logic [cws_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tlast: last_symbol.
    input  wire logic                          s_tlast,
    // Output stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: chip_sum [4:0], chip_index [7:5].
    output logic [cws_pkg::M_DATA_W-1:0]       m_tdata,
    // m_tlast: last_chip.
    output logic                               m_tlast,
    // m_tuser: end_of_message.
    output logic                               m_tuser
);
    import cws_pkg::*;

    localparam int               CNT_W    = $clog2(CODE_LEN);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CODE_LEN - 1);

    cws_cfg_t cfg;

    // Holding register for the symbol position being spread.
    logic                    hold_valid_reg;
    logic                    hold_valid_next;
    logic [S_DATA_W-1:0]     hold_syms_reg;
    logic                    hold_last_reg;
    logic [CNT_W-1:0]        chip_cnt_reg;
    logic [CNT_W-1:0]        chip_cnt_next;

    // Output register.
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [M_DATA_W-1:0]     m_tdata_reg;
    logic                    m_tlast_reg;
    logic                    m_tuser_reg;

    logic                    out_free;
    logic                    advance;
    logic                    final_chip;
    logic                    release_item;
    logic                    s_accept;
    logic signed [SUM_W-1:0] chip_sum;

    cws_cfg #(
        .CODE_LEN (CODE_LEN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cws_chip #(
        .CODE_LEN (CODE_LEN)
    ) u_chip (
        .syms     (hold_syms_reg),
        .chip_idx (chip_cnt_reg),
        .cfg      (cfg),
        .chip_sum (chip_sum)
    );

    // A chip is produced whenever an item is held and the output can take it.
    assign out_free     = !m_tvalid_reg || m_tready;
    assign advance      = hold_valid_reg && out_free;
    assign final_chip   = (chip_cnt_reg == LAST_IDX);
    assign release_item = advance && final_chip;

    // The holding register frees up on the cycle its last chip is loaded.
    assign s_tready = !hold_valid_reg || release_item;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (s_accept)
            hold_valid_next = 1'b1;
        else if (release_item)
            hold_valid_next = 1'b0;
    end

    always_comb
    begin
        chip_cnt_next = chip_cnt_reg;
        if (advance)
            chip_cnt_next = final_chip ? '0 : chip_cnt_reg + CNT_W'(1);
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_free)
            m_tvalid_next = advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            chip_cnt_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            chip_cnt_reg   <= chip_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            hold_syms_reg <= s_tdata;
            hold_last_reg <= s_tlast;
        end
        if (advance)
        begin
            m_tdata_reg <= {IDX_W'(chip_cnt_reg), chip_sum};
            m_tlast_reg <= final_chip;
            m_tuser_reg <= final_chip && hold_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // End of message can only ride on the last chip of an item.
    a_eom_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("end_of_message without last_chip");

    // An item stays held until its last chip has been loaded.
    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !final_chip) |=> hold_valid_reg)
        else $error("item dropped before its last chip");

    // A new item only overwrites a held one on the cycle that one finishes.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && hold_valid_reg) |-> release_item)
        else $error("held item overwritten");

    // The chip counter moves only when a chip is loaded.
    a_cnt_still: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(chip_cnt_reg))
        else $error("chip counter moved without a chip");

endmodule

`default_nettype wire
